[src/hkx_pkg.sv]
package hkx_pkg;

  localparam int unsigned HEADERS        = 9;
  localparam int unsigned MAX_HEADER_LEN = 80;
  localparam int unsigned HIDX_W         = 4;
  localparam int unsigned POS_W          = 7;
  localparam int unsigned STORE_DEPTH    = HEADERS * MAX_HEADER_LEN;
  localparam int unsigned ADDR_W         = $clog2(STORE_DEPTH);
  localparam int unsigned HSEL_W         = $clog2(HEADERS);
  localparam int unsigned KIDX_W         = $clog2(MAX_HEADER_LEN);
  localparam logic [7:0]  T_START        = 8'd7;
  localparam logic [7:0]  T_STEP         = 8'd13;

  typedef enum logic [2:0] {
    REQ_SET_LEN  = 3'd0,
    REQ_WR_BYTE  = 3'd1,
    REQ_BUILD    = 3'd2,
    REQ_DECODE   = 3'd3,
    REQ_CLEAR    = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    MODE_MODEL = 2'd0,
    MODE_MEDIA = 2'd1,
    MODE_DATA  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECT   = 2'd1,
    ST_NO_TABLE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH_RD,
    S_HASH_ACC,
    S_HASH_FIN,
    S_FILL,
    S_HDR,
    S_SEED,
    S_KEY_RD,
    S_KEY_WR,
    S_DEC,
    S_RESP
  } fsm_t;

  // controller -> datapath
  typedef struct packed {
    logic build_start;
    logic hash_rd;
    logic hash_acc;
    logic fill_start;
    logic fill;
    logic seed_init;
    logic seed_step;
    logic key_rd;
    logic key_wr;
    logic hdr_next;
    logic dec;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic no_table;
    logic maxlen_zero;
    logic hash_last;
    logic k_last;
    logic hdr_empty;
    logic hdr_last;
    logic seed_zero;
  } sts_t;

endpackage

[src/hkx_if.sv]
interface hkx_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [3:0] header_index;
  logic [6:0] byte_pos;
  logic [7:0] value;
  logic [1:0] key_mode;
  modport source (output valid, req_type, header_index, byte_pos, value, key_mode,
                  input ready);
  modport sink (input valid, req_type, header_index, byte_pos, value, key_mode,
                output ready);
endinterface

interface hkx_out_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic [1:0] status;
  modport source (output valid, data_out, status, input ready);
  modport sink (input valid, data_out, status, output ready);
endinterface

[src/hkx_datapath.sv]
module hkx_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_fire,
  input  logic [2:0]        req_type,
  input  logic [3:0]        header_index,
  input  logic [6:0]        byte_pos,
  input  logic [7:0]        value,
  input  logic [1:0]        key_mode,
  input  hkx_pkg::cmd_t     cmd,
  output hkx_pkg::sts_t     sts,
  output logic [7:0]        res_data,
  output logic [1:0]        res_status
);
  import hkx_pkg::*;

  logic [7:0] store [STORE_DEPTH];
  logic [7:0] key_table [MAX_HEADER_LEN];
  logic [6:0] lengths [HEADERS];

  logic [6:0]        key_length;
  logic [KIDX_W-1:0] key_position;
  logic [7:0]        last_cipher;
  logic [1:0]        mode;
  logic [6:0]        maxlen;
  logic [6:0]        maxlen_c;
  logic [HSEL_W-1:0] hi;
  logic [HSEL_W-1:0] rd_hi;
  logic [6:0]        j;
  logic [6:0]        rd_j;
  logic [6:0]        off;
  logic [6:0]        off_inc;
  logic [6:0]        off_adv;
  logic [KIDX_W-1:0] k;
  logic [KIDX_W-1:0] key_raddr;
  logic [6:0]        cur_len;
  logic [6:0]        rd_len;
  logic [KIDX_W-1:0] pos_wrap;
  logic [7:0]        t;
  logic [7:0]        t_base;
  logic [7:0]        cnt;
  logic [7:0]        seed;
  logic [7:0]        h;
  logic [7:0]        rd_data;
  logic [7:0]        key_rd_data;
  logic [7:0]        dec_val;
  logic [15:0]       prod;
  logic [7:0]        term;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              hidx_ok;
  logic              pos_ok;
  logic              no_table;

  assign hidx_ok  = header_index < HIDX_W'(HEADERS);
  assign pos_ok   = byte_pos < POS_W'(MAX_HEADER_LEN);
  assign wr_addr  = ADDR_W'(header_index) * ADDR_W'(MAX_HEADER_LEN) + ADDR_W'(byte_pos);
  assign rd_addr  = ADDR_W'(hi) * ADDR_W'(MAX_HEADER_LEN) + ADDR_W'(off);
  assign cur_len  = lengths[hi];
  assign off_inc  = (off + 7'd1 >= cur_len) ? 7'd0 : off + 7'd1;
  // data mode: offset tracks t mod len, so it restarts when the 8-bit t wraps
  assign off_adv  = (mode == MODE_DATA && t == 8'hFF) ? 7'd0 : off_inc;
  assign key_raddr = cmd.key_rd ? k : key_position;
  assign pos_wrap = (key_position + 7'd1 >= key_length) ? 7'd0 : key_position + 7'd1;
  assign no_table = (key_length == 7'd0) && (maxlen_c == 7'd0);

  assign prod = 16'(rd_data) * 16'({1'b0, rd_j} + 8'd1);
  assign term = 8'(rd_hi) + {1'b0, rd_j} + ((rd_len != 7'd0) ? prod[7:0] : 8'd0);

  always_comb begin
    maxlen_c = '0;
    for (int i = 0; i < HEADERS; i++) begin
      if (lengths[i] > maxlen_c) maxlen_c = lengths[i];
    end
  end

  // starting count of the offset walk for one header
  always_comb begin
    case (mode)
      MODE_MODEL: seed = 8'd0;
      MODE_MEDIA: seed = 8'(hi);
      default:    seed = t_base;
    endcase
  end

  // header store: one write, one registered read
  always_ff @(posedge clk) begin
    if (req_fire && req_type == REQ_WR_BYTE && hidx_ok && pos_ok) begin
      store[wr_addr] <= value;
    end
    rd_data <= store[rd_addr];
    rd_len  <= cur_len;
    rd_j    <= j;
    rd_hi   <= hi;
  end

  always_ff @(posedge clk) begin
    if (cmd.fill) key_table[k] <= h;
    else if (cmd.key_wr) key_table[k] <= key_rd_data ^ rd_data;
    key_rd_data <= key_table[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HEADERS; i++) lengths[i] <= '0;
      key_length   <= '0;
      key_position <= '0;
      last_cipher  <= '0;
    end else begin
      if (req_fire) begin
        mode       <= key_mode;
        dec_val    <= value;
        res_data   <= '0;
        res_status <= ST_OK;
        unique case (req_type)
          REQ_SET_LEN: begin
            if (!hidx_ok || value > 8'(MAX_HEADER_LEN)) res_status <= ST_REJECT;
            else lengths[header_index] <= value[6:0];
          end
          REQ_WR_BYTE: begin
            if (!hidx_ok || !pos_ok) res_status <= ST_REJECT;
          end
          REQ_BUILD: begin
            if (key_mode > MODE_DATA) res_status <= ST_REJECT;
            else if (no_table) res_status <= ST_NO_TABLE;
          end
          REQ_DECODE: begin
          end
          REQ_CLEAR: begin
            key_position <= '0;
            last_cipher  <= '0;
          end
          default: res_status <= ST_REJECT;
        endcase
      end
      if (cmd.build_start) begin
        maxlen <= maxlen_c;
        if (key_length == 7'd0) key_length <= maxlen_c;
        hi     <= '0;
        j      <= '0;
        off    <= '0;
        h      <= '0;
        k      <= '0;
        t_base <= T_START;
      end
      if (cmd.hash_rd) begin
        if (j + 7'd1 >= maxlen) begin
          j   <= '0;
          off <= '0;
          if (hi != HSEL_W'(HEADERS - 1)) hi <= hi + HSEL_W'(1);
        end else begin
          j   <= j + 7'd1;
          off <= off_inc;
        end
      end
      if (cmd.hash_acc) begin
        if (mode == MODE_MODEL) begin
          if (rd_len != 7'd0) h <= h ^ rd_data;
        end else begin
          h <= h ^ term;
        end
      end
      if (cmd.fill_start) begin
        hi <= '0;
        k  <= '0;
      end
      if (cmd.fill) k <= k + 7'd1;
      if (cmd.seed_init) begin
        off <= '0;
        t   <= '0;
        k   <= '0;
        cnt <= seed;
      end
      if (cmd.seed_step) begin
        off <= off_adv;
        t   <= t + 8'd1;
        cnt <= cnt - 8'd1;
      end
      if (cmd.key_rd) begin
        off <= off_adv;
        t   <= t + 8'd1;
      end
      if (cmd.key_wr) k <= k + 7'd1;
      if (cmd.hdr_next) begin
        hi     <= hi + HSEL_W'(1);
        t_base <= t_base + T_STEP;
      end
      if (cmd.dec) begin
        if (key_length == 7'd0) begin
          res_status <= ST_NO_TABLE;
        end else begin
          res_data     <= dec_val ^ last_cipher ^ key_rd_data;
          last_cipher  <= dec_val;
          key_position <= pos_wrap;
        end
      end
    end
  end

  assign sts.no_table    = no_table;
  assign sts.maxlen_zero = maxlen_c == 7'd0;
  assign sts.hash_last   = (hi == HSEL_W'(HEADERS - 1)) && (j + 7'd1 >= maxlen);
  assign sts.k_last      = k + 7'd1 >= key_length;
  assign sts.hdr_empty   = cur_len == 7'd0;
  assign sts.hdr_last    = hi == HSEL_W'(HEADERS - 1);
  assign sts.seed_zero   = cnt == 8'd0;
endmodule

[src/hkx_ctrl.sv]
module hkx_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    req_type,
  input  logic [1:0]    key_mode,
  output logic          out_valid,
  input  logic          out_ready,
  output hkx_pkg::cmd_t cmd,
  input  hkx_pkg::sts_t sts
);
  import hkx_pkg::*;

  fsm_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    in_ready       = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !out_valid || out_ready;
        if (in_valid && in_ready) begin
          if (req_type == REQ_BUILD && key_mode <= MODE_DATA && !sts.no_table) begin
            cmd.build_start = 1'b1;
            state_next = sts.maxlen_zero ? S_FILL : S_HASH_RD;
          end else if (req_type == REQ_DECODE) begin
            state_next = S_DEC;
          end else begin
            out_valid_next = 1'b1;
          end
        end
      end
      S_HASH_RD: begin
        cmd.hash_rd = 1'b1;
        state_next = sts.hash_last ? S_HASH_FIN : S_HASH_ACC;
      end
      S_HASH_ACC: begin
        cmd.hash_acc = 1'b1;
        state_next = S_HASH_RD;
      end
      S_HASH_FIN: begin
        cmd.hash_acc   = 1'b1;
        cmd.fill_start = 1'b1;
        state_next = S_FILL;
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (sts.k_last) state_next = S_HDR;
      end
      S_HDR: begin
        if (sts.hdr_empty) begin
          if (sts.hdr_last) state_next = S_RESP;
          else cmd.hdr_next = 1'b1;
        end else begin
          cmd.seed_init = 1'b1;
          state_next = S_SEED;
        end
      end
      S_SEED: begin
        if (sts.seed_zero) state_next = S_KEY_RD;
        else cmd.seed_step = 1'b1;
      end
      S_KEY_RD: begin
        cmd.key_rd = 1'b1;
        state_next = S_KEY_WR;
      end
      S_KEY_WR: begin
        cmd.key_wr = 1'b1;
        if (!sts.k_last) begin
          state_next = S_KEY_RD;
        end else if (sts.hdr_last) begin
          state_next = S_RESP;
        end else begin
          cmd.hdr_next = 1'b1;
          state_next = S_HDR;
        end
      end
      S_DEC: begin
        cmd.dec = 1'b1;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      S_RESP: begin
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

[src/header_keyed_xor_chain_decrypt.sv]
// Decode: the transfer moves to S_DEC, which registers the result; no request is taken meanwhile.
// Length/byte writes, clear, rejects: registered at transfer; one item per cycle if output is taken.
// Build: a hash pass over all headers, a key table fill, then per non-empty header a seed walk
// (seed: 0 model, index media, 7+13*index data) and a key pass; one store read port.
// Reset (rst, synchronous) clears lengths, key length, position and chain; header bytes stay unknown.
module header_keyed_xor_chain_decrypt (
  input logic      clk,
  input logic      rst,
  hkx_in_if.sink   in_ch,
  hkx_out_if.source out_ch
);
  import hkx_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hkx_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .req_type (in_ch.req_type), .key_mode (in_ch.key_mode),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts
  );

  hkx_datapath u_dp (
    .clk, .rst,
    .req_fire    (in_ch.valid && in_ch.ready),
    .req_type    (in_ch.req_type),
    .header_index(in_ch.header_index),
    .byte_pos    (in_ch.byte_pos),
    .value       (in_ch.value),
    .key_mode    (in_ch.key_mode),
    .cmd, .sts,
    .res_data    (out_ch.data_out),
    .res_status  (out_ch.status)
  );
endmodule
